// File: rtl/assert_macros.svh
// Shared assertion shorthands. Each one samples on the rising edge of clk
// and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// When the condition holds, the consequence must hold at the next sampled edge.
`define CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

  // Field widths of the pixel words.
  localparam int unsigned HueW   = 16;
  localparam int unsigned PctW   = 8;
  localparam int unsigned LevelW = 8;

  // Percent and degree limits.
  localparam int unsigned PctFull = 100;
  localparam int unsigned DegFull = 360;
  localparam int unsigned LightSplit = 50;

  // Hue reduction: q = (h * HueRecip) >> HueShift is the exact quotient h / 360
  // for every 16-bit h.
  localparam int unsigned HueRecip = 11651;
  localparam int unsigned HueShift = 22;

  // Level scaling: v * 255 / 600000 equals (v * 17) / 40000, and the quotient by
  // 40000 is (y * LevelRecip) >> LevelShift, exact for y up to 10200000.
  localparam int unsigned LevelMul   = 17;
  localparam int unsigned LevelRecip = 1717987;
  localparam int unsigned LevelShift = 36;

  // Grey path: l * 255 / 100 equals ((l * 51) >> 2) / 5, and the quotient by 5
  // is (x * GreyRecip) >> GreyShift for x up to 1275.
  localparam int unsigned GreyMul   = 51;
  localparam int unsigned GreyRecip = 13108;
  localparam int unsigned GreyShift = 16;

  // Channel slots.
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;
  localparam int unsigned NumCh   = 3;

  typedef logic [8:0] hue_t;
  typedef logic [5:0] weight_t;

  // Weight of the hi level in the ramp, out of 60, for one hue offset.
  function automatic weight_t ramp_weight(input hue_t off);
    hue_t fall;
    fall = hue_t'(240) - off;
    if (off < hue_t'(60)) begin
      return off[5:0];
    end else if (off < hue_t'(180)) begin
      return weight_t'(60);
    end else if (off < hue_t'(240)) begin
      return fall[5:0];
    end else begin
      return weight_t'(0);
    end
  endfunction

endpackage

// File: rtl/hsl2rgb_in_if.sv
interface hsl2rgb_in_if;
  logic                             valid;
  logic                             ready;
  logic [hsl2rgb_pkg::HueW-1:0]     hue_degrees;
  logic [hsl2rgb_pkg::PctW-1:0]     saturation_pct;
  logic [hsl2rgb_pkg::PctW-1:0]     lightness_pct;

  modport source (output valid, hue_degrees, saturation_pct, lightness_pct,
                  input ready);
  modport sink (input valid, hue_degrees, saturation_pct, lightness_pct,
                output ready);
endinterface

// File: rtl/hsl2rgb_out_if.sv
interface hsl2rgb_out_if;
  logic                             valid;
  logic                             ready;
  logic [hsl2rgb_pkg::LevelW-1:0]   red_level;
  logic [hsl2rgb_pkg::LevelW-1:0]   green_level;
  logic [hsl2rgb_pkg::LevelW-1:0]   blue_level;

  modport source (output valid, red_level, green_level, blue_level,
                  input ready);
  modport sink (input valid, red_level, green_level, blue_level,
                output ready);
endinterface

// File: rtl/hsl_to_rgb_integer.sv
// HSL to RGB converter, six register stages, one word in and one word out.
// Throughput: one word per cycle while the output is ready; each stage holds
// only while the one after it is full and stalled, so bubbles are squeezed out
// under backpressure.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
`include "assert_macros.svh"

module hsl_to_rgb_integer (
  input  logic                 clk,
  input  logic                 rst,
  hsl2rgb_in_if.sink           pix_in,
  hsl2rgb_out_if.source        pix_out
);

  localparam int unsigned NumStg = 6;

  // Stage valid bits and per-stage load enables.
  logic [NumStg-1:0] vld;
  logic [NumStg:0]   ld;

  // Stage 1: clamped inputs, saturation-lightness product, hue quotient.
  logic [15:0] hue1;
  logic [6:0]  sat1;
  logic [6:0]  lit1;
  logic [13:0] ls1;
  logic [7:0]  hq1;
  logic [6:0]  sat_clip;
  logic [6:0]  lit_clip;
  logic [29:0] hue_prod;

  // Stage 2: reduced hue, hi level, doubled lightness, grey numerator.
  hsl2rgb_pkg::hue_t hue2;
  logic [13:0] hi2;
  logic [14:0] l200_2;
  logic [12:0] gl2;
  logic        szero2;
  logic [16:0] hue_rem;
  logic [14:0] hi_calc;

  // Stage 3: lo level, spread, ramp weights, grey level.
  logic [13:0] lo3;
  logic [13:0] diff3;
  logic [hsl2rgb_pkg::NumCh-1:0][5:0] wt3;
  logic [7:0]  grey3;
  logic        szero3;
  logic [14:0] lo_calc;
  logic [14:0] diff_calc;
  logic [hsl2rgb_pkg::NumCh-1:0][8:0] off_calc;
  logic [24:0] grey_prod;

  // Stage 4: ramp value out of 600000.
  logic [hsl2rgb_pkg::NumCh-1:0][19:0] v4;
  logic [7:0]  grey4;
  logic        szero4;

  // Stage 5: ramp value times 17.
  logic [hsl2rgb_pkg::NumCh-1:0][23:0] y5;
  logic [7:0]  grey5;
  logic        szero5;

  // Stage 6: final levels.
  logic [hsl2rgb_pkg::NumCh-1:0][7:0] lvl6;
  logic [hsl2rgb_pkg::NumCh-1:0][44:0] lvl_prod;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    ld[NumStg] = pix_out.ready;
    for (int i = NumStg - 1; i >= 0; i--) begin
      ld[i] = ~vld[i] | ld[i+1];
    end
  end

  assign pix_in.ready = ld[0];

  // Valid bits move along with their stage data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1 logic: clamp to 100 percent and start the hue division.
  always_comb begin
    sat_clip = (pix_in.saturation_pct > 8'(hsl2rgb_pkg::PctFull)) ?
               7'(hsl2rgb_pkg::PctFull) : pix_in.saturation_pct[6:0];
    lit_clip = (pix_in.lightness_pct > 8'(hsl2rgb_pkg::PctFull)) ?
               7'(hsl2rgb_pkg::PctFull) : pix_in.lightness_pct[6:0];
    hue_prod = 30'(pix_in.hue_degrees) * 30'(hsl2rgb_pkg::HueRecip);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      hue1 <= pix_in.hue_degrees;
      sat1 <= sat_clip;
      lit1 <= lit_clip;
      ls1  <= 14'(sat_clip) * 14'(lit_clip);
      hq1  <= hue_prod[hsl2rgb_pkg::HueShift +: 8];
    end
  end

  // Stage 2 logic: hue remainder and the hi level.
  always_comb begin
    hue_rem = 17'(hue1) - 17'(hq1) * 17'(hsl2rgb_pkg::DegFull);
    if (lit1 < 7'(hsl2rgb_pkg::LightSplit)) begin
      hi_calc = 15'(lit1) * 15'(hsl2rgb_pkg::PctFull) + 15'(ls1);
    end else begin
      hi_calc = (15'(lit1) + 15'(sat1)) * 15'(hsl2rgb_pkg::PctFull) - 15'(ls1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      hue2   <= hue_rem[8:0];
      hi2    <= hi_calc[13:0];
      l200_2 <= 15'(lit1) * 15'(200);
      gl2    <= 13'(lit1) * 13'(hsl2rgb_pkg::GreyMul);
      szero2 <= (sat1 == 7'd0);
    end
  end

  // Stage 3 logic: lo level, spread between levels, per-channel hue offsets.
  always_comb begin
    lo_calc   = l200_2 - 15'(hi2);
    diff_calc = (15'(hi2) << 1) - l200_2;
    off_calc[hsl2rgb_pkg::ChGreen] = hue2;
    off_calc[hsl2rgb_pkg::ChRed]   = (hue2 < 9'(240)) ? hue2 + 9'(120) : hue2 - 9'(240);
    off_calc[hsl2rgb_pkg::ChBlue]  = (hue2 >= 9'(120)) ? hue2 - 9'(120) : hue2 + 9'(240);
    grey_prod = 25'(gl2[12:2]) * 25'(hsl2rgb_pkg::GreyRecip);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      lo3    <= lo_calc[13:0];
      diff3  <= diff_calc[13:0];
      for (int c = 0; c < hsl2rgb_pkg::NumCh; c++) begin
        wt3[c] <= hsl2rgb_pkg::ramp_weight(off_calc[c]);
      end
      grey3  <= grey_prod[hsl2rgb_pkg::GreyShift +: 8];
      szero3 <= szero2;
    end
  end

  // Stage 4: lo * 60 plus the weighted spread.
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int c = 0; c < hsl2rgb_pkg::NumCh; c++) begin
        v4[c] <= 20'(lo3) * 20'(60) + 20'(diff3) * 20'(wt3[c]);
      end
      grey4  <= grey3;
      szero4 <= szero3;
    end
  end

  // Stage 5: scale by 17 ahead of the division by 40000.
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int c = 0; c < hsl2rgb_pkg::NumCh; c++) begin
        y5[c] <= 24'(v4[c]) * 24'(hsl2rgb_pkg::LevelMul);
      end
      grey5  <= grey4;
      szero5 <= szero4;
    end
  end

  // Stage 6: reciprocal multiply for the division, then pick grey if unsaturated.
  always_comb begin
    for (int c = 0; c < hsl2rgb_pkg::NumCh; c++) begin
      lvl_prod[c] = 45'(y5[c]) * 45'(hsl2rgb_pkg::LevelRecip);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int c = 0; c < hsl2rgb_pkg::NumCh; c++) begin
        lvl6[c] <= szero5 ? grey5 : lvl_prod[c][hsl2rgb_pkg::LevelShift +: 8];
      end
    end
  end

  assign pix_out.valid       = vld[NumStg-1];
  assign pix_out.red_level   = lvl6[hsl2rgb_pkg::ChRed];
  assign pix_out.green_level = lvl6[hsl2rgb_pkg::ChGreen];
  assign pix_out.blue_level  = lvl6[hsl2rgb_pkg::ChBlue];

  // The hue reduction must land in one turn.
  `CHECK_ALWAYS(a_hue_reduced, !vld[1] || (hue2 < 9'(hsl2rgb_pkg::DegFull)), "hue remainder out of range")
  // The hi level never lies below the lo level.
  `CHECK_ALWAYS(a_level_order, !vld[1] || ((15'(hi2) << 1) >= l200_2), "hi level below lo level")
  // A stalled output word is never dropped.
  `CHECK_NEXT(a_out_held, vld[NumStg-1] && !pix_out.ready, vld[NumStg-1], "stalled output word lost")

endmodule

// File: sim/tb_hsl_to_rgb_integer.sv
module tb_hsl_to_rgb_integer;

  localparam int unsigned HueW       = hsl2rgb_pkg::HueW;
  localparam int unsigned PctW       = hsl2rgb_pkg::PctW;
  localparam int unsigned LevelW     = hsl2rgb_pkg::LevelW;
  localparam int unsigned DegFull    = hsl2rgb_pkg::DegFull;
  localparam int unsigned PctFull    = hsl2rgb_pkg::PctFull;
  localparam int unsigned LightSplit = hsl2rgb_pkg::LightSplit;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned LongHold      = 64;
  localparam int unsigned NumChunks     = 14;
  localparam int unsigned ChunkWords    = 100;
  localparam int unsigned FloodWords    = 40;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned NumRows       = 25;
  localparam int unsigned MaxReports    = 10;

  typedef enum int unsigned {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] light;
  } hsl_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } rgb_t;

  typedef struct {
    hsl_t color;
    rgb_t rgb;
  } rgb_expect_t;

  typedef struct {
    logic [HueW-1:0]   hue;
    logic [PctW-1:0]   sat;
    logic [PctW-1:0]   light;
    bit                known;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } stim_row_t;

  logic clk;
  logic rst;

  hsl2rgb_in_if  pix_in ();
  hsl2rgb_out_if pix_out ();

  hsl_to_rgb_integer dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  rgb_expect_t pending_rgb[$];
  idle_mode_e  idle_mode = IDLE_LIGHT;
  bit          hold_request = 1'b0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  stim_row_t   directed_rows [0:NumRows-1];

  // Level of one channel for a hue offset, ramping between the two lightness levels.
  function automatic logic [LevelW-1:0] ramp_to_level(input int unsigned lo,
                                                      input int unsigned hi,
                                                      input int unsigned off);
    int unsigned acc;
    if (off < 60) begin
      acc = lo * 60 + (hi - lo) * off;
    end else if (off < 180) begin
      acc = hi * 60;
    end else if (off < 240) begin
      acc = lo * 60 + (hi - lo) * (240 - off);
    end else begin
      acc = lo * 60;
    end
    return LevelW'((acc * 255) / 600000);
  endfunction

  // Predicted RGB word for one HSL word.
  function automatic rgb_t predict_rgb(input hsl_t c);
    int unsigned h;
    int unsigned s;
    int unsigned l;
    int unsigned hi;
    int unsigned lo;
    rgb_t res;
    h = int'(c.hue) % DegFull;
    s = (int'(c.sat) > PctFull) ? PctFull : int'(c.sat);
    l = (int'(c.light) > PctFull) ? PctFull : int'(c.light);
    if (s == 0) begin
      res.red   = LevelW'((l * 255) / PctFull);
      res.green = res.red;
      res.blue  = res.red;
    end else begin
      if (l < LightSplit) begin
        hi = l * (PctFull + s);
      end else begin
        hi = (l + s) * PctFull - s * l;
      end
      lo = l * 200 - hi;
      res.red   = ramp_to_level(lo, hi, (h + 120) % DegFull);
      res.green = ramp_to_level(lo, hi, h);
      res.blue  = ramp_to_level(lo, hi, (h + 240) % DegFull);
    end
    return res;
  endfunction

  // Length of an idle stretch: mostly short, a few long.
  function automatic int unsigned pick_gap(input idle_mode_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      IDLE_NONE: begin
        return 0;
      end
      IDLE_LIGHT: begin
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
      default: begin
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
    endcase
  endfunction

  // Random colour, weighted toward the clamp and boundary regions.
  function automatic hsl_t random_hsl();
    hsl_t c;
    case ($urandom_range(0, 3))
      0: c.hue = HueW'($urandom_range(0, 359));
      1: c.hue = HueW'($urandom);
      2: c.hue = HueW'($urandom_range(0, 6) * 60 + $urandom_range(0, 2) + 359) % HueW'(720);
      default: c.hue = HueW'($urandom_range(360, 719));
    endcase
    case ($urandom_range(0, 9))
      0: c.sat = '0;
      1, 2: c.sat = PctW'($urandom);
      3: c.sat = PctW'($urandom_range(101, 255));
      default: c.sat = PctW'($urandom_range(1, 100));
    endcase
    case ($urandom_range(0, 9))
      0: c.light = PctW'($urandom_range(48, 51));
      1, 2: c.light = PctW'($urandom);
      3: c.light = PctW'($urandom_range(101, 255));
      default: c.light = PctW'($urandom_range(0, 100));
    endcase
    return c;
  endfunction

  // Offer one word, wait for it to be taken, record its expected result, then maybe idle.
  task automatic send_word(input hsl_t c, input bit known, input rgb_t typed);
    rgb_expect_t e;
    int unsigned gap;
    @(negedge clk);
    pix_in.valid          <= 1'b1;
    pix_in.hue_degrees    <= c.hue;
    pix_in.saturation_pct <= c.sat;
    pix_in.lightness_pct  <= c.light;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    e.color = c;
    e.rgb   = known ? typed : predict_rgb(c);
    pending_rgb.push_back(e);
    words_sent++;
    gap = pick_gap(idle_mode);
    if (gap > 0) begin
      @(negedge clk);
      pix_in.valid          <= 1'b0;
      pix_in.hue_degrees    <= HueW'($urandom);
      pix_in.saturation_pct <= PctW'($urandom);
      pix_in.lightness_pct  <= PctW'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Withdraw the offer, then wait until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold when the stimulus asks for it.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    pix_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pix_out.ready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        pix_out.ready <= 1'b0;
        stall_left = LongHold - 1;
      end else begin
        stall_left = pick_gap(idle_mode);
        if (stall_left > 0) begin
          pix_out.ready <= 1'b0;
          stall_left--;
        end else begin
          pix_out.ready <= 1'b1;
        end
      end
    end
  end

  // Result checker: each output word against the oldest expectation.
  always @(posedge clk) begin
    rgb_expect_t e;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (pending_rgb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("Unexpected word: rgb %0d %0d %0d", pix_out.red_level,
                   pix_out.green_level, pix_out.blue_level);
        end
      end else begin
        e = pending_rgb.pop_front();
        words_checked++;
        if (pix_out.red_level !== e.rgb.red || pix_out.green_level !== e.rgb.green ||
            pix_out.blue_level !== e.rgb.blue) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("Mismatch for hsl %0d %0d %0d: expected rgb %0d %0d %0d, got %0d %0d %0d",
                     e.color.hue, e.color.sat, e.color.light,
                     e.rgb.red, e.rgb.green, e.rgb.blue,
                     pix_out.red_level, pix_out.green_level, pix_out.blue_level);
          end
        end
      end
    end
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending_rgb.size());
      $display("hsl_to_rgb_integer verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    rgb_t typed;
    hsl_t c;
    pix_in.valid          = 1'b0;
    pix_in.hue_degrees    = '0;
    pix_in.saturation_pct = '0;
    pix_in.lightness_pct  = '0;
    rst = 1'b1;

    // Hue, saturation, lightness, known flag, then red, green, blue where known.
    directed_rows = '{
      '{16'd0,     8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
      '{16'd0,     8'd0,   8'd100, 1'b1, 8'd255, 8'd255, 8'd255},
      '{16'd0,     8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
      '{16'd200,   8'd0,   8'd50,  1'b1, 8'd127, 8'd127, 8'd127},
      '{16'd0,     8'd100, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
      '{16'd0,     8'd100, 8'd100, 1'b1, 8'd255, 8'd255, 8'd255},
      '{16'd0,     8'd100, 8'd50,  1'b1, 8'd255, 8'd0,   8'd0},
      '{16'd120,   8'd100, 8'd50,  1'b1, 8'd0,   8'd255, 8'd0},
      '{16'd240,   8'd100, 8'd50,  1'b1, 8'd0,   8'd0,   8'd255},
      '{16'd360,   8'd100, 8'd50,  1'b1, 8'd255, 8'd0,   8'd0},
      '{16'd0,     8'd255, 8'd50,  1'b1, 8'd255, 8'd0,   8'd0},
      '{16'd65535, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
      '{16'd65535, 8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
      '{16'd65535, 8'd100, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd59,    8'd100, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd60,    8'd80,  8'd40,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd179,   8'd73,  8'd61,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd180,   8'd100, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd239,   8'd55,  8'd70,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd300,   8'd100, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd359,   8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd30,    8'd37,  8'd49,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd30,    8'd37,  8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd32768, 8'd170, 8'd99,  1'b0, 8'd0,   8'd0,   8'd0},
      '{16'd719,   8'd101, 8'd101, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: grey, primaries, clamps, hue wrap and ramp corners.
    idle_mode = IDLE_LIGHT;
    for (int i = 0; i < NumRows; i++) begin
      c.hue   = directed_rows[i].hue;
      c.sat   = directed_rows[i].sat;
      c.light = directed_rows[i].light;
      typed.red   = directed_rows[i].red;
      typed.green = directed_rows[i].green;
      typed.blue  = directed_rows[i].blue;
      send_word(c, directed_rows[i].known, typed);
    end

    // Random words in chunks, cycling through the idle patterns.
    typed = '0;
    for (int chunk = 0; chunk < NumChunks; chunk++) begin
      if (chunk == 3) begin
        // Sender pauses until the pipeline has emptied.
        wait_drained();
      end
      if (chunk == 6) begin
        // Output held off for a long stretch while the sender keeps offering words.
        wait_drained();
        idle_mode = IDLE_NONE;
        hold_request = 1'b1;
        for (int i = 0; i < FloodWords; i++) begin
          send_word(random_hsl(), 1'b0, typed);
        end
      end
      idle_mode = idle_mode_e'(chunk % 3);
      for (int i = 0; i < ChunkWords; i++) begin
        send_word(random_hsl(), 1'b0, typed);
      end
    end

    @(negedge clk);
    pix_in.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d words (%0d directed) and checked %0d results, %0d mismatches.",
             words_sent, NumRows, words_checked, mismatch_count);
    $display("Covered grey, primaries, hue wrap, clamped percents and a %0d-cycle output hold.",
             LongHold);
    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("hsl_to_rgb_integer verification clean");
    end else begin
      $display("hsl_to_rgb_integer verification failed");
    end
    $finish;
  end

endmodule
